### rtl/core/nsfc_pkg.sv
// Package of constants, types and helper functions for the NMEA sentence framer and checker.
`default_nettype none

package nsfc_pkg;

	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_COMMA  = 8'h2C;
	localparam logic [7:0] CH_A      = 8'h41;

	localparam int unsigned WIN_BYTES = 6;
	localparam int unsigned WIN_BITS  = WIN_BYTES * 8;

	localparam logic [WIN_BITS-1:0] HDR_KSXT  = 48'h24_4B_53_58_54_2C;
	localparam logic [WIN_BITS-1:0] HDR_GPRMC = 48'h47_50_52_4D_43_2C;

	localparam logic [7:0] XOR_KSXT  = 8'h4B ^ 8'h53 ^ 8'h58 ^ 8'h54 ^ 8'h2C;
	localparam logic [7:0] XOR_GPRMC = 8'h47 ^ 8'h50 ^ 8'h52 ^ 8'h4D ^ 8'h43 ^ 8'h2C;

	localparam logic [2:0] STAR_CLOSE = 3'd3;
	localparam logic [2:0] STAR_MAX   = 3'd7;
	localparam logic [5:0] COMMA_MAX  = 6'd63;

	typedef enum logic {
		KIND_KSXT  = 1'b0,
		KIND_GPRMC = 1'b1
	} kind_t;

	typedef struct packed {
		logic [WIN_BITS-1:0] win;
		logic [7:0]          running_xor;
		logic [2:0]          star_count;
		logic [7:0]          received_value;
		logic                hex_stopped;
		logic [5:0]          comma_count;
		logic                status_flag;
		logic                status_pending;
	} sent_state_t;

	typedef struct packed {
		kind_t      sentence_kind;
		logic       checksum_ok;
		logic [7:0] computed_checksum;
		logic [7:0] received_checksum;
		logic [5:0] field_count;
		logic       status_active;
	} result_t;

	// Returns a valid bit above the four-bit value of a hexadecimal character.
	function automatic logic [4:0] hex_digit(input logic [7:0] c);
		logic [4:0] r;
		r = 5'd0;
		if (c >= 8'h30 && c <= 8'h39) begin
			r = {1'b1, c[3:0]};
		end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
			r = {1'b1, c[3:0] + 4'd9};
		end
		return r;
	endfunction

endpackage

`default_nettype wire

### rtl/core/nsfc_in_if.sv
// Interface of the received byte channel.
`default_nettype none

interface nsfc_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/core/nsfc_out_if.sv
// Interface of the sentence result channel.
`default_nettype none

interface nsfc_out_if;
	logic       valid;
	logic       ready;
	logic       sentence_kind;
	logic       checksum_ok;
	logic [7:0] computed_checksum;
	logic [7:0] received_checksum;
	logic [5:0] field_count;
	logic       status_active;

	modport source (
		output valid, output sentence_kind, output checksum_ok,
		output computed_checksum, output received_checksum,
		output field_count, output status_active,
		input ready
	);
	modport sink (
		input valid, input sentence_kind, input checksum_ok,
		input computed_checksum, input received_checksum,
		input field_count, input status_active,
		output ready
	);
endinterface

`default_nettype wire

### rtl/core/nmea_sentence_framer_checker.sv
// Top level of the NMEA sentence framer and checksum checker.
`default_nettype none

// One received byte is taken per clock cycle, sustained, whenever the result side is not
// stalled; a byte passes an input register and then updates the sentence state, and the
// result of a byte that closes its sentence enters the output register with that update.
// A sentence opens on the header "$KSXT," or "GPRMC,", closes on the second character after
// its first '*' unless that is a '*' too (then only a '$' ends it), and gives one result;
// a '$' always restarts the search and no other byte outside a sentence gives a result.
module nmea_sentence_framer_checker (
	input wire logic  clk,
	input wire logic  arst_n,
	nsfc_in_if.sink   rx,
	nsfc_out_if.source res
);
	import nsfc_pkg::*;

	logic        valid_s1;
	logic [7:0]  byte_s1;
	sent_state_t state_q;
	sent_state_t state_nxt;
	logic        emit;
	result_t     step_res;
	logic        out_valid_q;
	result_t     result_q;
	logic        advance;

	nsfc_step u_step (
		.c   (byte_s1),
		.cur (state_q),
		.nxt (state_nxt),
		.emit(emit),
		.res (step_res)
	);

	assign advance  = valid_s1 && (!out_valid_q || res.ready);
	assign rx.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.valid && rx.ready) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.valid && rx.ready) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (advance) begin
			state_q <= state_nxt;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= emit;
		end else if (res.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			result_q <= step_res;
		end
	end

	assign res.valid             = out_valid_q;
	assign res.sentence_kind     = result_q.sentence_kind;
	assign res.checksum_ok       = result_q.checksum_ok;
	assign res.computed_checksum = result_q.computed_checksum;
	assign res.received_checksum = result_q.received_checksum;
	assign res.field_count       = result_q.field_count;
	assign res.status_active     = result_q.status_active;

`ifndef SYNTHESIS
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |-> rx.ready)
		else $error("byte request refused while the input register is empty");

	a_clear_after_close: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> (state_q.star_count == 3'd0 && state_q.comma_count == 6'd0))
		else $error("sentence state not cleared after a result");

	a_field_count_min: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.field_count >= 6'd2))
		else $error("result with fewer than two fields");

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !emit && !out_valid_q) |=> !res.valid)
		else $error("result presented without a closing byte");
`endif

endmodule

`default_nettype wire

### rtl/core/nsfc_step.sv
// Next-state and result logic for one received byte of the sentence framer.
`default_nettype none

module nsfc_step (
	input  wire logic [7:0]          c,
	input  wire nsfc_pkg::sent_state_t cur,
	output nsfc_pkg::sent_state_t      nxt,
	output logic                       emit,
	output nsfc_pkg::result_t          res
);
	import nsfc_pkg::*;

	logic                is_ksxt;
	logic                is_gprmc;
	logic [4:0]          hex;
	logic [2:0]          star_inc;
	logic [WIN_BITS-1:0] win_shift;
	logic [7:0]          computed;
	logic [6:0]          fc_sum;

	always_comb begin
		is_ksxt   = (cur.win == HDR_KSXT);
		is_gprmc  = (cur.win == HDR_GPRMC);
		hex       = hex_digit(c);
		star_inc  = (cur.star_count != STAR_MAX) ? cur.star_count + 3'd1 : cur.star_count;
		win_shift = {cur.win[WIN_BITS-9:0], c};
		nxt       = cur;
		emit      = 1'b0;
		res       = '0;
		computed  = 8'd0;
		fc_sum    = 7'd0;

		if (c == CH_DOLLAR || !(is_ksxt || is_gprmc)) begin
			nxt     = '0;
			nxt.win = win_shift;
		end else begin
			if (cur.status_pending) begin
				nxt.status_flag    = (c == CH_A);
				nxt.status_pending = 1'b0;
			end
			if (c == CH_COMMA) begin
				if (cur.comma_count != COMMA_MAX) begin
					nxt.comma_count = cur.comma_count + 6'd1;
				end
				if (nxt.comma_count == 6'd1) begin
					nxt.status_pending = 1'b1;
				end
			end
			if (cur.star_count == 3'd0 && c != CH_STAR) begin
				nxt.running_xor = cur.running_xor ^ c;
			end
			if (cur.star_count == 3'd1 || cur.star_count == 3'd2) begin
				if (!cur.hex_stopped && hex[4]) begin
					nxt.received_value = {cur.received_value[3:0], hex[3:0]};
				end else begin
					nxt.hex_stopped = 1'b1;
				end
			end
			if (c == CH_STAR) begin
				nxt.star_count = star_inc;
			end else if (cur.star_count != 3'd0) begin
				nxt.star_count = star_inc;
				if (star_inc == STAR_CLOSE) begin
					emit     = 1'b1;
					computed = nxt.running_xor ^ (is_gprmc ? XOR_GPRMC : XOR_KSXT);
					fc_sum   = {1'b0, nxt.comma_count} + 7'd2;
					res.sentence_kind     = is_gprmc ? KIND_GPRMC : KIND_KSXT;
					res.checksum_ok       = (computed == nxt.received_value);
					res.computed_checksum = computed;
					res.received_checksum = nxt.received_value;
					res.field_count       = (fc_sum > 7'd63) ? COMMA_MAX : fc_sum[5:0];
					res.status_active     = nxt.status_flag;
					nxt     = '0;
					nxt.win = win_shift;
				end
			end
		end
	end

endmodule

`default_nettype wire

### sim/nsfc_sentence_check.sv
// Checker that frames the received bytes, predicts each sentence result and compares it.
`timescale 1ns / 100ps

module nsfc_sentence_check (
	input wire logic clk,
	input wire logic arst_n,
	nsfc_in_if       rx,
	nsfc_out_if      res,
	output int       errors,
	output int       due,
	output int       closed,
	output int       matched,
	output int       gprmc_seen
);
	import nsfc_pkg::*;

	logic [WIN_BITS-1:0] win;
	logic [7:0]          body_xor;
	logic [2:0]          stars;
	logic [7:0]          sum_seen;
	logic                hex_done;
	logic [5:0]          commas;
	logic                status_seen;
	logic                status_armed;
	result_t             sentences_due[$];

	initial begin
		errors = 0;
		due = 0;
		closed = 0;
		matched = 0;
		gprmc_seen = 0;
	end

	function automatic logic [4:0] hex_of(input logic [7:0] c);
		if (c inside {[8'h30:8'h39]}) begin
			return {1'b1, 4'(c - 8'h30)};
		end else if (c inside {[8'h41:8'h46]}) begin
			return {1'b1, 4'(c - 8'h37)};
		end else if (c inside {[8'h61:8'h66]}) begin
			return {1'b1, 4'(c - 8'h57)};
		end
		return 5'd0;
	endfunction

	task automatic drop_sentence();
		body_xor = 8'd0;
		stars = 3'd0;
		sum_seen = 8'd0;
		hex_done = 1'b0;
		commas = 6'd0;
		status_seen = 1'b0;
		status_armed = 1'b0;
	endtask

	task automatic report_mismatch(input string what);
		errors++;
		if (errors <= 40) begin
			$display("%0t: sentence %0d: %s", $time, closed, what);
		end
	endtask

	// Advances the framing state by one received byte and queues a result when a sentence closes.
	task automatic take_byte(input logic [7:0] c);
		kind_t      kind;
		logic       open;
		logic [2:0] prior;
		logic [4:0] digit;
		logic [6:0] fields;
		result_t    want;
		open = 1'b0;
		kind = KIND_KSXT;
		if (c != CH_DOLLAR && win == HDR_KSXT) begin
			open = 1'b1;
		end else if (c != CH_DOLLAR && win == HDR_GPRMC) begin
			open = 1'b1;
			kind = KIND_GPRMC;
		end
		if (!open) begin
			win = {win[WIN_BITS-9:0], c};
			drop_sentence();
		end else begin
			if (status_armed) begin
				status_seen = (c == CH_A);
				status_armed = 1'b0;
			end
			if (c == CH_COMMA) begin
				if (commas != COMMA_MAX) begin
					commas++;
				end
				if (commas == 6'd1) begin
					status_armed = 1'b1;
				end
			end
			prior = stars;
			if (prior == 3'd0 && c != CH_STAR) begin
				body_xor ^= c;
			end
			if (prior == 3'd1 || prior == 3'd2) begin
				digit = hex_of(c);
				if (!hex_done && digit[4]) begin
					sum_seen = {sum_seen[3:0], digit[3:0]};
				end else begin
					hex_done = 1'b1;
				end
			end
			if (c == CH_STAR) begin
				if (stars != STAR_MAX) begin
					stars++;
				end
			end else if (stars != 3'd0) begin
				if (stars != STAR_MAX) begin
					stars++;
				end
				if (stars == STAR_CLOSE) begin
					want.sentence_kind = kind;
					want.computed_checksum = body_xor ^
						((kind == KIND_GPRMC) ? XOR_GPRMC : XOR_KSXT);
					want.received_checksum = sum_seen;
					want.checksum_ok = (want.computed_checksum == sum_seen);
					fields = {1'b0, commas} + 7'd2;
					want.field_count = (fields > 7'd63) ? COMMA_MAX : fields[5:0];
					want.status_active = status_seen;
					sentences_due.insert(sentences_due.size(), want);
					win = {win[WIN_BITS-9:0], c};
					drop_sentence();
				end
			end
		end
	endtask

	task automatic compare_result();
		result_t want;
		if (sentences_due.size() == 0) begin
			report_mismatch("result with no sentence outstanding");
		end else begin
			want = sentences_due.pop_front();
			if (res.sentence_kind !== want.sentence_kind) begin
				report_mismatch($sformatf("sentence_kind %b, expected %b",
					res.sentence_kind, want.sentence_kind));
			end
			if (res.checksum_ok !== want.checksum_ok) begin
				report_mismatch($sformatf("checksum_ok %b, expected %b",
					res.checksum_ok, want.checksum_ok));
			end
			if (res.computed_checksum !== want.computed_checksum) begin
				report_mismatch($sformatf("computed_checksum %h, expected %h",
					res.computed_checksum, want.computed_checksum));
			end
			if (res.received_checksum !== want.received_checksum) begin
				report_mismatch($sformatf("received_checksum %h, expected %h",
					res.received_checksum, want.received_checksum));
			end
			if (res.field_count !== want.field_count) begin
				report_mismatch($sformatf("field_count %0d, expected %0d",
					res.field_count, want.field_count));
			end
			if (res.status_active !== want.status_active) begin
				report_mismatch($sformatf("status_active %b, expected %b",
					res.status_active, want.status_active));
			end
			if (want.checksum_ok) begin
				matched++;
			end
			if (want.sentence_kind == KIND_GPRMC) begin
				gprmc_seen++;
			end
		end
		closed++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win = '0;
			drop_sentence();
			sentences_due.delete();
		end else begin
			if (rx.valid && rx.ready) begin
				take_byte(rx.rx_byte);
			end
			if (res.valid && res.ready) begin
				compare_result();
			end
		end
		due = sentences_due.size();
	end

endmodule

### sim/nmea_sentence_framer_checker_test.sv
// Testbench top: byte stream stimulus, result side stalls and the final verdict.
`timescale 1ns / 100ps

module nmea_sentence_framer_checker_test;
	import nsfc_pkg::*;

	localparam int CYCLE_LIMIT   = 400000;
	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 10;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic hold_req = 1'b0;
	bit   calm = 1'b0;
	int   cycles = 0;
	int   sent = 0;
	int   burst_left = 0;
	int   holds = 0;
	int   pauses = 0;
	int   errors, due, closed, matched, gprmc_seen;
	logic [7:0] line_q[$];

	nsfc_in_if  rx();
	nsfc_out_if res();

	nmea_sentence_framer_checker dut (
		.clk    (clk),
		.arst_n (arst_n),
		.rx     (rx),
		.res    (res)
	);

	nsfc_sentence_check check (
		.clk        (clk),
		.arst_n     (arst_n),
		.rx         (rx),
		.res        (res),
		.errors     (errors),
		.due        (due),
		.closed     (closed),
		.matched    (matched),
		.gprmc_seen (gprmc_seen)
	);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("nmea_sentence_framer_checker_test: done, errors");
			$finish;
		end
	end

	initial begin : receiver
		int hold_left;
		int on_left;
		int off_left;
		hold_left = 0;
		on_left = 0;
		off_left = 0;
		res.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req <= 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res.ready = 1'b0;
			end else if (calm) begin
				res.ready = 1'b1;
			end else if (on_left > 0) begin
				on_left--;
				res.ready = 1'b1;
			end else if (off_left > 0) begin
				off_left--;
				res.ready = 1'b0;
			end else begin
				on_left = $urandom_range(1, 24);
				off_left = $urandom_range(1, 6);
				res.ready = 1'b1;
			end
		end
	end

	function automatic logic [7:0] hex_char(input logic [3:0] n, input bit lower);
		if (n < 4'd10) begin
			return 8'h30 + 8'(n);
		end
		return (lower ? 8'h61 : 8'h41) + 8'(n) - 8'd10;
	endfunction

	function automatic logic [7:0] non_hex();
		logic [7:0] c;
		do begin
			c = 8'($urandom_range(0, 255));
		end while (c inside {[8'h30:8'h39], [8'h41:8'h46], [8'h61:8'h66], CH_DOLLAR, CH_STAR});
		return c;
	endfunction

	function automatic logic [7:0] body_char();
		logic [7:0] c;
		case ($urandom_range(0, 9))
			0, 1, 2, 3: c = 8'h30 + 8'($urandom_range(0, 9));
			4, 5: c = 8'h41 + 8'($urandom_range(0, 25));
			6: c = 8'h2E;
			7: c = 8'h61 + 8'($urandom_range(0, 25));
			8: c = CH_A;
			default: begin
				do begin
					c = 8'($urandom_range(0, 255));
				end while (c == CH_DOLLAR || c == CH_STAR);
			end
		endcase
		return c;
	endfunction

	task automatic append_byte(input logic [7:0] c);
		line_q.insert(line_q.size(), c);
	endtask

	task automatic push_text(input string s);
		for (int i = 0; i < s.len(); i++) begin
			append_byte(s[i]);
		end
	endtask

	task automatic push_hex(input logic [7:0] v, input bit lower);
		append_byte(hex_char(v[7:4], lower));
		append_byte(hex_char(v[3:0], lower));
	endtask

	// Offers one byte, opening a new burst after a random gap when the current one is spent.
	task automatic offer(input logic [7:0] c);
		int gap;
		if (!calm && burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = $urandom_range(0, 6);
			if (gap > 0) begin
				rx.valid = 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		if (burst_left > 0) begin
			burst_left--;
		end
		rx.valid = 1'b1;
		rx.rx_byte = c;
		do begin
			@(posedge clk);
		end while (!rx.ready);
		@(negedge clk);
		sent++;
	endtask

	task automatic send_line();
		while (line_q.size() > 0) begin
			offer(line_q.pop_front());
		end
	endtask

	// Builds one sentence with random content; a broken one is cut short or has a restart inside.
	task automatic make_sentence(input bit broken);
		logic [7:0] sum;
		logic [7:0] c;
		int         fields_n;
		int         len;
		int         style;
		bit         gprmc;
		gprmc = 1'($urandom_range(0, 1));
		if ($urandom_range(0, 3) == 0) begin
			append_byte(8'($urandom_range(0, 255)));
		end
		if (!gprmc) begin
			push_text("$KSXT,");
			sum = XOR_KSXT;
		end else begin
			if ($urandom_range(0, 1)) begin
				append_byte(CH_DOLLAR);
			end
			push_text("GPRMC,");
			sum = XOR_GPRMC;
		end
		if ($urandom_range(0, 40) == 0) begin
			len = $urandom_range(60, 70);
			repeat (len) begin
				append_byte(CH_COMMA);
				sum ^= CH_COMMA;
			end
		end else begin
			fields_n = $urandom_range(0, 6);
			for (int f = 0; f < fields_n; f++) begin
				if (f > 0) begin
					append_byte(CH_COMMA);
					sum ^= CH_COMMA;
				end
				len = $urandom_range(0, 6);
				for (int i = 0; i < len; i++) begin
					c = (f == 1 && i == 0 && $urandom_range(0, 1)) ? CH_A : body_char();
					append_byte(c);
					sum ^= c;
				end
			end
		end
		append_byte(CH_STAR);
		style = $urandom_range(0, 9);
		if (style < 6) begin
			push_hex(sum, 1'($urandom_range(0, 1)));
		end else if (style == 6) begin
			push_hex(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
		end else if (style == 7) begin
			append_byte(hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1))));
			append_byte(non_hex());
		end else if (style == 8) begin
			append_byte(non_hex());
			append_byte(8'($urandom_range(0, 255)));
		end else if ($urandom_range(0, 1)) begin
			append_byte(CH_STAR);
			append_byte(non_hex());
		end else begin
			append_byte(hex_char(4'($urandom_range(0, 15)), 1'b0));
			append_byte(CH_STAR);
		end
		if ($urandom_range(0, 1)) begin
			push_text("\r\n");
		end
		if (broken) begin
			if ($urandom_range(0, 1)) begin
				line_q = line_q[0:$urandom_range(0, line_q.size() - 2)];
			end else begin
				line_q.insert($urandom_range(1, line_q.size() - 1), CH_DOLLAR);
			end
		end
	endtask

	initial begin : stimulus
		int round;
		int pick;
		round = 0;
		rx.valid = 1'b0;
		rx.rx_byte = 8'd0;
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		append_byte(8'h00);
		append_byte(8'hFF);
		push_text("$KSXT,*");
		push_hex(XOR_KSXT, 1'b0);
		push_text("GPRMC,,A*");
		push_hex(XOR_GPRMC ^ CH_COMMA ^ CH_A, 1'b1);
		push_text("$KSXT,*1*");
		send_line();

		while (sent < 1300) begin
			round++;
			if (round % 12 == 0) begin
				calm <= ($urandom_range(0, 3) == 0);
			end
			if (round == 10 || round == 45) begin
				hold_req <= 1'b1;
				holds++;
			end
			if (round % 25 == 0) begin
				rx.valid = 1'b0;
				wait (due == 0);
				@(negedge clk);
				pauses++;
			end
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				repeat ($urandom_range(1, 8)) append_byte(8'($urandom_range(0, 255)));
			end else begin
				make_sentence(pick == 1);
			end
			send_line();
		end

		rx.valid = 1'b0;
		wait (due == 0);
		repeat (SETTLE_CYCLES) @(negedge clk);

		$display("Run covered %0d bytes in %0d rounds; %0d sentences closed, %0d with a good sum,",
			sent, round, closed, matched);
		$display("%0d of them GPRMC; %0d long result hold-offs and %0d full drains of the input.",
			gprmc_seen, holds, pauses);
		if (errors == 0) begin
			$display("nmea_sentence_framer_checker_test: done, clean");
		end else begin
			$display("nmea_sentence_framer_checker_test: done, errors");
		end
		$finish;
	end

endmodule
